FILE: sv/ssd_dec_pkg.sv
// Shared types and constants of the SSD anchor decoder.
`default_nettype none
package ssd_dec_pkg;

    localparam int SCORE_W  = 16;
    localparam int BOX_W    = 16;
    localparam int CLASS_W  = 8;
    localparam int SCALE_W  = 13;
    localparam int COORD_W  = 17;
    localparam int CORNER_SHIFT = 11;

    localparam int MAX_CLASSES = 256;
    localparam int QUEUE_DEPTH = 4;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 96;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic signed [SCORE_W-1:0] SCORE_MINUS_ONE = 16'sh8000;
    localparam logic signed [SCORE_W-1:0] THRESHOLD_RESET = 16'sd24576;
    localparam logic [SCALE_W-1:0]        IMAGE_SIZE_RESET = 13'd300;
    localparam logic [BOX_W-1:0]          ONE_Q15 = 16'h8000;

    typedef enum logic [1:0] {
        REG_SCORE_THRESHOLD = 2'd0,
        REG_IMAGE_WIDTH     = 2'd1,
        REG_IMAGE_HEIGHT    = 2'd2,
        REG_UNUSED          = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [CLASS_W-1:0]        class_index;
        logic signed [SCORE_W-1:0] best_score;
        logic signed [BOX_W-1:0]   center_y;
        logic signed [BOX_W-1:0]   center_x;
        logic signed [BOX_W-1:0]   box_height;
        logic signed [BOX_W-1:0]   box_width;
    } cand_t;

endpackage
`default_nettype wire

FILE: sv/ssd_dec_front.sv
// Front end: running argmax over class scores and detection qualification.
`default_nettype none
module ssd_dec_front (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               in_fire,
    input  wire signed [ssd_dec_pkg::SCORE_W-1:0] class_score,
    input  wire                               last_class,
    input  wire signed [ssd_dec_pkg::BOX_W-1:0]   center_y,
    input  wire signed [ssd_dec_pkg::BOX_W-1:0]   center_x,
    input  wire signed [ssd_dec_pkg::BOX_W-1:0]   box_height,
    input  wire signed [ssd_dec_pkg::BOX_W-1:0]   box_width,
    input  wire signed [ssd_dec_pkg::SCORE_W-1:0] thresh,
    output logic                              push,
    output ssd_dec_pkg::cand_t                push_data
);
    import ssd_dec_pkg::*;

    localparam int unsigned PosLimit = MAX_CLASSES - 1;

    logic signed [SCORE_W-1:0] best_score_reg, best_score_next;
    logic [CLASS_W-1:0]        best_class_reg, best_class_next;
    logic [CLASS_W-1:0]        position_reg, position_next;
    logic                      win;
    logic signed [SCORE_W-1:0] cur_score;
    logic [CLASS_W-1:0]        cur_class;

    always_comb begin
        win       = class_score > best_score_reg;
        cur_score = win ? class_score : best_score_reg;
        cur_class = win ? position_reg : best_class_reg;

        best_score_next = best_score_reg;
        best_class_next = best_class_reg;
        position_next   = position_reg;
        if (in_fire) begin
            if (last_class) begin
                best_score_next = SCORE_MINUS_ONE;
                best_class_next = '0;
                position_next   = '0;
            end else begin
                best_score_next = cur_score;
                best_class_next = cur_class;
                if ({24'd0, position_reg} < PosLimit) begin
                    position_next = position_reg + 8'd1;
                end
            end
        end

        push = in_fire && last_class && (cur_score > thresh) && (cur_class != '0);
        push_data.class_index = cur_class;
        push_data.best_score  = cur_score;
        push_data.center_y    = center_y;
        push_data.center_x    = center_x;
        push_data.box_height  = box_height;
        push_data.box_width   = box_width;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_score_reg <= SCORE_MINUS_ONE;
            best_class_reg <= '0;
            position_reg   <= '0;
        end else begin
            best_score_reg <= best_score_next;
            best_class_reg <= best_class_next;
            position_reg   <= position_next;
        end
    end

endmodule
`default_nettype wire

FILE: sv/ssd_dec_queue.sv
// Short queue of qualified detections between the front and back ends.
`default_nettype none
module ssd_dec_queue (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 push,
    input  ssd_dec_pkg::cand_t  push_data,
    output logic                full,
    input  wire                 pop,
    output logic                not_empty,
    output ssd_dec_pkg::cand_t  pop_data
);
    import ssd_dec_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    cand_t           entry_reg [QUEUE_DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [AW:0]     count_reg, count_next;
    logic            do_push, do_pop;

    always_comb begin
        full      = count_reg == (AW+1)'(QUEUE_DEPTH);
        not_empty = count_reg != '0;
        pop_data  = entry_reg[rd_ptr_reg];
        do_push   = push && !full;
        do_pop    = pop && not_empty;

        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

FILE: sv/ssd_dec_back.sv
// Back end: corner clipping, pixel scaling and the output register.
`default_nettype none
module ssd_dec_back (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                cand_valid,
    input  ssd_dec_pkg::cand_t                 cand,
    output logic                               cand_pop,
    input  wire [ssd_dec_pkg::SCALE_W-1:0]     scale_x,
    input  wire [ssd_dec_pkg::SCALE_W-1:0]     scale_y,
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [ssd_dec_pkg::M_TDATA_W-1:0]  m_tdata
);
    import ssd_dec_pkg::*;

    localparam int C2_W   = BOX_W + 2;
    localparam int PROD_W = BOX_W + SCALE_W;

    function automatic logic [BOX_W-1:0] clip_unit(input logic signed [C2_W-1:0] v);
        logic [BOX_W-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > $signed({2'b00, ONE_Q15})) begin
            r = ONE_Q15;
        end else begin
            r = v[BOX_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [COORD_W-1:0] scale_px(input logic [BOX_W-1:0] c,
                                                     input logic [SCALE_W-1:0] s);
        logic [PROD_W-1:0] p;
        p = PROD_W'(c) * PROD_W'(s);
        return p[CORNER_SHIFT+COORD_W-1:CORNER_SHIFT];
    endfunction

    logic                      st1_valid_reg;
    logic [CLASS_W-1:0]        st1_class_reg;
    logic signed [SCORE_W-1:0] st1_score_reg;
    logic [BOX_W-1:0]          st1_left_reg, st1_top_reg, st1_right_reg, st1_bottom_reg;

    logic                      out_valid_reg;
    logic [CLASS_W-1:0]        out_class_reg;
    logic signed [SCORE_W-1:0] out_score_reg;
    logic [COORD_W-1:0]        out_left_reg, out_top_reg, out_right_reg, out_bottom_reg;

    logic                      out_ready, st1_ready;
    logic signed [C2_W-1:0]    cx2, cy2, bw_x, bh_x;

    always_comb begin
        out_ready = !out_valid_reg || m_tready;
        st1_ready = !st1_valid_reg || out_ready;
        cand_pop  = cand_valid && st1_ready;

        cx2  = {cand.center_x[BOX_W-1], cand.center_x, 1'b0};
        cy2  = {cand.center_y[BOX_W-1], cand.center_y, 1'b0};
        bw_x = {{2{cand.box_width[BOX_W-1]}}, cand.box_width};
        bh_x = {{2{cand.box_height[BOX_W-1]}}, cand.box_height};

        m_tvalid = out_valid_reg;
        m_tdata  = {4'd0, out_bottom_reg, out_right_reg, out_top_reg, out_left_reg,
                    out_score_reg, out_class_reg};
    end

    always_ff @(posedge aclk) begin
        if (st1_ready) begin
            st1_class_reg  <= cand.class_index;
            st1_score_reg  <= cand.best_score;
            st1_left_reg   <= clip_unit(cx2 - bw_x);
            st1_top_reg    <= clip_unit(cy2 - bh_x);
            st1_right_reg  <= clip_unit(cx2 + bw_x);
            st1_bottom_reg <= clip_unit(cy2 + bh_x);
        end
        if (out_ready) begin
            out_class_reg  <= st1_class_reg;
            out_score_reg  <= st1_score_reg;
            out_left_reg   <= scale_px(st1_left_reg, scale_x);
            out_top_reg    <= scale_px(st1_top_reg, scale_y);
            out_right_reg  <= scale_px(st1_right_reg, scale_x);
            out_bottom_reg <= scale_px(st1_bottom_reg, scale_y);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (st1_ready) begin
                st1_valid_reg <= cand_valid;
            end
            if (out_ready) begin
                out_valid_reg <= st1_valid_reg;
            end
        end
    end

endmodule
`default_nettype wire

FILE: sv/ssd_anchor_decode_top.sv
// Top level of the SSD anchor decoder: configuration registers and stream wiring.
// One class score word is taken per cycle while s_tready is high, including the word
// flagged with tlast that closes an anchor. The running argmax is updated in the same
// cycle a word is taken; a qualifying anchor goes through a four-entry queue, a clip
// stage and a scaling stage with four 16x13 multipliers to m_tdata. The input stalls
// only while that queue is full, which happens only under output back-pressure. The
// user must write APB configuration only while idle; the block does not enforce it.
`default_nettype none
module ssd_anchor_decode_top (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    // class_score[15:0], center_y[31:16], center_x[47:32], box_height[63:48],
    // box_width[79:64]
    input  wire [ssd_dec_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire                                 s_tlast,
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    // class_index[7:0], best_score_out[23:8], left_x[40:24], top_y[57:41],
    // right_x[74:58], bottom_y[91:75], zero[95:92]
    output logic [ssd_dec_pkg::M_TDATA_W-1:0]   m_tdata,
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire [ssd_dec_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire [ssd_dec_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [ssd_dec_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                pready
);
    import ssd_dec_pkg::*;

    logic signed [SCORE_W-1:0] threshold_reg;
    logic [SCALE_W-1:0]        width_reg;
    logic [SCALE_W-1:0]        height_reg;

    reg_index_t reg_sel;
    logic       wr_en;

    logic  in_fire;
    logic  push, full, pop, not_empty;
    cand_t push_data, pop_data;

    always_comb begin
        pready  = 1'b1;
        reg_sel = reg_index_t'(paddr[3:2]);
        wr_en   = psel && penable && pwrite && pready;
        case (reg_sel)
            REG_SCORE_THRESHOLD: prdata = {{16{threshold_reg[SCORE_W-1]}}, threshold_reg};
            REG_IMAGE_WIDTH:     prdata = {19'd0, width_reg};
            REG_IMAGE_HEIGHT:    prdata = {19'd0, height_reg};
            default:             prdata = '0;
        endcase
        s_tready = !full;
        in_fire  = s_tvalid && s_tready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESHOLD_RESET;
            width_reg     <= IMAGE_SIZE_RESET;
            height_reg    <= IMAGE_SIZE_RESET;
        end else if (wr_en) begin
            case (reg_sel)
                REG_SCORE_THRESHOLD: threshold_reg <= pwdata[SCORE_W-1:0];
                REG_IMAGE_WIDTH:     width_reg     <= pwdata[SCALE_W-1:0];
                REG_IMAGE_HEIGHT:    height_reg    <= pwdata[SCALE_W-1:0];
                default:             ;
            endcase
        end
    end

    ssd_dec_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_fire         (in_fire),
        .class_score     (s_tdata[15:0]),
        .last_class      (s_tlast),
        .center_y        (s_tdata[31:16]),
        .center_x        (s_tdata[47:32]),
        .box_height      (s_tdata[63:48]),
        .box_width       (s_tdata[79:64]),
        .thresh          (threshold_reg),
        .push            (push),
        .push_data       (push_data)
    );

    ssd_dec_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .pop_data  (pop_data)
    );

    ssd_dec_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cand_valid   (not_empty),
        .cand         (pop_data),
        .cand_pop     (pop),
        .scale_x      (width_reg),
        .scale_y      (height_reg),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule
`default_nettype wire

FILE: sim/ssd_anchor_decode_top_test.sv
// Self-checking stream and APB regression of the SSD anchor decoder.
module ssd_anchor_decode_top_test;
    import ssd_dec_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int LONG_HOLD    = 300;

    typedef struct {
        logic signed [SCORE_W-1:0] score;
        logic                      last;
        logic signed [BOX_W-1:0]   cy;
        logic signed [BOX_W-1:0]   cx;
        logic signed [BOX_W-1:0]   bh;
        logic signed [BOX_W-1:0]   bw;
    } score_word_t;

    typedef struct {
        logic [CLASS_W-1:0]        class_index;
        logic signed [SCORE_W-1:0] best_score;
        logic [COORD_W-1:0]        left_x;
        logic [COORD_W-1:0]        top_y;
        logic [COORD_W-1:0]        right_x;
        logic [COORD_W-1:0]        bottom_y;
    } detection_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    ssd_anchor_decode_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 aclk = ~aclk;

    logic signed [SCORE_W-1:0] threshold_cfg = THRESHOLD_RESET;
    logic [SCALE_W-1:0]        width_cfg = IMAGE_SIZE_RESET;
    logic [SCALE_W-1:0]        height_cfg = IMAGE_SIZE_RESET;
    logic signed [SCORE_W-1:0] best_score_so_far = SCORE_MINUS_ONE;
    logic [CLASS_W-1:0]        best_class_so_far = '0;
    int                        class_pos = 0;

    score_word_t score_words[$];
    detection_t  detections_due[$];
    score_word_t current_word;

    int  words_queued = 0;
    int  words_accepted = 0;
    int  anchors_queued = 0;
    int  long_anchors = 0;
    int  detections_checked = 0;
    int  settings_used = 0;
    int  input_stall_cycles = 0;
    int  fault_count = 0;
    int  cycle_count = 0;
    int  burst_left = 0;
    int  gap_left = 0;
    int  ready_run = 0;
    int  hold_left = 0;
    bit  sender_steady = 1'b0;
    bit  receiver_steady = 1'b0;
    bit  hold_request = 1'b0;
    bit  hold_taken = 1'b0;

    task automatic report_fault(input string msg);
        if (fault_count < 100) begin
            $display("ERROR: %s", msg);
        end
        fault_count++;
    endtask

    function automatic logic [COORD_W-1:0] pixel_corner(input int c2,
                                                        input logic [SCALE_W-1:0] scale);
        longint clipped;
        clipped = (c2 < 0) ? 0 : ((c2 > int'(ONE_Q15)) ? int'(ONE_Q15) : c2);
        return COORD_W'((clipped * longint'(scale)) >> CORNER_SHIFT);
    endfunction

    task automatic decode_anchor_word(input score_word_t w);
        detection_t d;
        if (w.score > best_score_so_far) begin
            best_score_so_far = w.score;
            best_class_so_far = CLASS_W'(class_pos);
        end
        if (class_pos < MAX_CLASSES - 1) begin
            class_pos++;
        end
        if (w.last) begin
            if (best_score_so_far > threshold_cfg && best_class_so_far != '0) begin
                d.class_index = best_class_so_far;
                d.best_score  = best_score_so_far;
                d.left_x      = pixel_corner(2 * int'(w.cx) - int'(w.bw), width_cfg);
                d.top_y       = pixel_corner(2 * int'(w.cy) - int'(w.bh), height_cfg);
                d.right_x     = pixel_corner(2 * int'(w.cx) + int'(w.bw), width_cfg);
                d.bottom_y    = pixel_corner(2 * int'(w.cy) + int'(w.bh), height_cfg);
                detections_due.insert(detections_due.size(), d);
            end
            best_score_so_far = SCORE_MINUS_ONE;
            best_class_so_far = '0;
            class_pos = 0;
        end
    endtask

    task automatic check_detection(input logic [M_TDATA_W-1:0] word);
        detection_t want;
        if (detections_due.size() == 0) begin
            report_fault($sformatf("unexpected detection, class %0d score %0h",
                word[7:0], word[23:8]));
        end else begin
            want = detections_due.pop_front();
            if (word[7:0] != want.class_index)
                report_fault($sformatf("detection %0d class_index: want %0d got %0d",
                    detections_checked, want.class_index, word[7:0]));
            if (word[23:8] != want.best_score)
                report_fault($sformatf("detection %0d best_score_out: want %0h got %0h",
                    detections_checked, want.best_score, word[23:8]));
            if (word[40:24] != want.left_x)
                report_fault($sformatf("detection %0d left_x: want %0h got %0h",
                    detections_checked, want.left_x, word[40:24]));
            if (word[57:41] != want.top_y)
                report_fault($sformatf("detection %0d top_y: want %0h got %0h",
                    detections_checked, want.top_y, word[57:41]));
            if (word[74:58] != want.right_x)
                report_fault($sformatf("detection %0d right_x: want %0h got %0h",
                    detections_checked, want.right_x, word[74:58]));
            if (word[91:75] != want.bottom_y)
                report_fault($sformatf("detection %0d bottom_y: want %0h got %0h",
                    detections_checked, want.bottom_y, word[91:75]));
            if (word[95:92] != '0)
                report_fault($sformatf("detection %0d padding bits set: %0h",
                    detections_checked, word[95:92]));
            detections_checked++;
        end
    endtask

    task automatic queue_word(input score_word_t w);
        score_words.insert(score_words.size(), w);
        words_queued++;
        if (w.last) begin
            anchors_queued++;
        end
    endtask

    task automatic push_word(input int score, input bit last, input int cy, input int cx,
                             input int bh, input int bw);
        score_word_t w;
        w.score = SCORE_W'(score);
        w.last  = last;
        w.cy    = BOX_W'(cy);
        w.cx    = BOX_W'(cx);
        w.bh    = BOX_W'(bh);
        w.bw    = BOX_W'(bw);
        queue_word(w);
    endtask

    function automatic logic signed [SCORE_W-1:0] pick_score();
        int lo;
        lo = int'(threshold_cfg) - 600;
        if (lo < -32768) begin
            lo = -32768;
        end
        case ($urandom_range(0, 9))
            0: return SCORE_MINUS_ONE;
            1: return 16'sh7fff;
            2: return threshold_cfg;
            3, 4, 5: return SCORE_W'(lo + int'($urandom_range(0, 32767 - lo)));
            default: return SCORE_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [BOX_W-1:0] box_value();
        return BOX_W'(-2048 + int'($urandom_range(0, 20480)));
    endfunction

    task automatic queue_random_anchor();
        int          n;
        bit          noisy;
        score_word_t w;
        case ($urandom_range(0, 59))
            0: n = $urandom_range(256, 300);
            1, 2, 3, 4: n = 1;
            default: n = $urandom_range(2, 12);
        endcase
        if (n > MAX_CLASSES - 1) begin
            long_anchors++;
        end
        noisy = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n; i++) begin
            w.score = pick_score();
            // hold early classes low so a class past the limit can win
            if (n > MAX_CLASSES - 1 && i < 250) begin
                w.score = SCORE_W'(-int'($urandom_range(1, 32768)));
            end
            w.last = (i == n - 1);
            if (noisy || !w.last) begin
                w.cy = BOX_W'($urandom);
                w.cx = BOX_W'($urandom);
                w.bh = BOX_W'($urandom);
                w.bw = BOX_W'($urandom);
            end else begin
                w.cy = box_value();
                w.cx = box_value();
                w.bh = box_value();
                w.bw = box_value();
            end
            queue_word(w);
        end
    endtask

    task automatic queue_random_words(input int target);
        int start;
        start = words_queued;
        while (words_queued - start < target) begin
            queue_random_anchor();
        end
    endtask

    task automatic write_register(input reg_index_t idx, input logic [APB_DATA_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SCORE_THRESHOLD: threshold_cfg = value[SCORE_W-1:0];
            REG_IMAGE_WIDTH:     width_cfg = value[SCALE_W-1:0];
            REG_IMAGE_HEIGHT:    height_cfg = value[SCALE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input int threshold, input int width, input int height);
        write_register(REG_SCORE_THRESHOLD, {16'($urandom), 16'(threshold)});
        write_register(REG_IMAGE_WIDTH, {19'($urandom), 13'(width)});
        write_register(REG_IMAGE_HEIGHT, {19'($urandom), 13'(height)});
        settings_used++;
    endtask

    task automatic wait_drained();
        while (!(words_accepted == words_queued && detections_due.size() == 0)) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && !s_tready) begin
                input_stall_cycles++;
            end
            if (s_tvalid && s_tready) begin
                decode_anchor_word(current_word);
                words_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (score_words.size() > 0) begin
                    current_word = score_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {current_word.bw, current_word.bh, current_word.cx,
                                 current_word.cy, current_word.score};
                    s_tlast  <= current_word.last;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 30);
                        gap_left = sender_steady ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_detection(m_tdata);
            end
            if (hold_request != hold_taken) begin
                hold_taken = hold_request;
                hold_left = LONG_HOLD - 1;
                m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (ready_run > 0) begin
                ready_run--;
            end else if (receiver_steady || !m_tready) begin
                m_tready <= 1'b1;
                ready_run = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                        : $urandom_range(0, 20);
            end else begin
                m_tready <= 1'b0;
                ready_run = $urandom_range(0, 6);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timed out after %0d cycles, %0d detections outstanding",
                     cycle_count, detections_due.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        push_word(32767, 1, -32768, 32767, 32767, -32768);
        push_word(-32768, 0, 0, 0, 0, 0);
        push_word(-32768, 1, 8192, 8192, 4096, 4096);
        push_word(32767, 0, 0, 0, 0, 0);
        push_word(100, 1, 8192, 8192, 4096, 4096);
        push_word(0, 0, 0, 0, 0, 0);
        push_word(24576, 1, 8192, 8192, 4096, 4096);
        push_word(0, 0, 0, 0, 0, 0);
        push_word(24577, 1, 8192, 8192, 16384, 16384);
        push_word(0, 0, 0, 0, 0, 0);
        push_word(30000, 0, 0, 0, 0, 0);
        push_word(30000, 1, -8192, -8192, -100, -100);
        push_word(-32768, 0, 0, 0, 0, 0);
        push_word(32767, 0, 0, 0, 0, 0);
        push_word(-1, 0, 0, 0, 0, 0);
        push_word(0, 1, 8192, 8192, -16384, -16384);
        push_word(1, 0, 0, 0, 0, 0);
        push_word(2, 0, 0, 0, 0, 0);
        push_word(3, 1, 4096, 4096, 2048, 2048);
        push_word(0, 0, 0, 0, 0, 0);
        push_word(0, 0, 0, 0, 0, 0);
        push_word(32767, 1, 32767, 32767, -32768, -32768);
        push_word(-5, 0, 0, 0, 0, 0);
        push_word(32767, 1, -32768, -32768, 32767, 32767);
        wait_drained();

        configure(-32768, 1, 8191);
        queue_random_words(350);
        wait_drained();

        configure(32767, 4096, 1);
        queue_random_words(150);
        wait_drained();

        configure(0, 0, 0);
        queue_random_words(200);
        wait_drained();

        // hold the output while the sender keeps pushing
        configure(-20000, 8191, 4096);
        @(negedge aclk);
        sender_steady = 1'b1;
        hold_request = ~hold_request;
        queue_random_words(400);
        wait_drained();

        for (int p = 0; p < 3; p++) begin
            configure(-8000 + int'($urandom_range(0, 38000)), int'($urandom_range(1, 4096)),
                      int'($urandom_range(1, 4096)));
            @(negedge aclk);
            sender_steady = ($urandom_range(0, 1) == 0);
            receiver_steady = (p == 1);
            queue_random_words(300);
            wait_drained();
        end

        $display("%0d score words in %0d anchors (%0d past the class limit), %0d detections",
                 words_accepted, anchors_queued, long_anchors, detections_checked);
        $display("%0d register settings incl. extreme thresholds and zero image size; %0s %0d",
                 settings_used, "input stall cycles", input_stall_cycles);
        if (fault_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
